>>> hw/rtl/literal_string_unescape_top_assert.svh
// Assertion macros shared by the literal string unescape RTL.
`ifndef LITERAL_STRING_UNESCAPE_TOP_ASSERT_SVH
`define LITERAL_STRING_UNESCAPE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LSU_ASSERT(lbl, expr, msg)
`define LSU_ASSERT_IMP(lbl, ante, cons, msg)
`define LSU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/lsu_pkg.sv
// Shared types and constants for the literal string unescape block.
package lsu_pkg;

  localparam int MAX_NEST_DEPTH = 255;
  localparam int DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EOD   = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_OCT1   = 3'd2,
    MODE_OCT2   = 3'd3,
    MODE_CR     = 3'd4,
    MODE_ESC_CR = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic [1:0] err;
  } result_t;

  // Up to two results from one decoded item, r0 first.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    result_t            res;
    logic               emit;
    mode_t              mode;
    logic [DEPTH_W-1:0] depth;
  } nb_t;

endpackage

>>> hw/rtl/literal_string_unescape_top.sv
// Top level of the literal string unescape block.
//
// Decodes the body of a parenthesized literal string, one raw byte per
// input transfer (in_byte, or in_end_of_data to mark end of source).
// Each input transfer yields zero, one or two result transfers: a decoded
// byte, a string end marker with an error code, or a flushed octal byte then either.
// Channels use valid/stall; a transfer happens when valid is high and
// stall is low. Valid never looks at stall.
// Path: a byte is held in the input register, decoded from there into the
// queue, and shows on the out_ ports when it reaches the queue head.
// Throughput: one input transfer per cycle while in_stall is low. Results
// drain one per cycle while out_stall is low, from a four-entry queue; an
// item is decoded only while the queue holds at most two entries. One
// spare entry absorbs the extra result of a flushed octal escape (two
// results); once it is taken, the next flush stalls input unless an input
// gap or an item with no result has let the queue drain.
// Receiver stall: the queue fills, the input register holds its byte and
// in_stall rises. No result is lost or repeated.
// Reset (rst_n low, synchronous): queue empty, input register empty,
// decoder at depth one in plain text mode.
module literal_string_unescape_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic [1:0] out_error_code
);
  import lsu_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eod_r;
  logic       room;
  logic       fire;
  push_t      push;

  // The held item is decoded once the queue can take two results.
  assign fire     = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_eod_r  <= in_end_of_data;
    end
  end

  lsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (in_byte_r),
    .eod_in  (in_eod_r),
    .push    (push)
  );

  lsu_out_fifo u_out_fifo (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_en         (fire),
    .push            (push),
    .room            (room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code)
  );
endmodule

>>> hw/rtl/lsu_decode.sv
// Escape and nesting decoder with its state registers.
`include "literal_string_unescape_top_assert.svh"
module lsu_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     byte_in,
  input  logic           eod_in,
  output lsu_pkg::push_t push
);
  import lsu_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [7:0]         oct_r, oct_nxt;
  logic [7:0]         oct_shift;
  nb_t                nb;

  // Plain text handling of one byte.
  function automatic nb_t normal_fn(input logic [7:0] c, input logic [DEPTH_W-1:0] d);
    nb_t r;
    r       = '0;
    r.emit  = 1'b1;
    r.mode  = MODE_NORMAL;
    r.depth = d;
    case (c)
      CH_LPAREN: begin
        if (d >= DEPTH_W'(MAX_NEST_DEPTH)) begin
          r.res.done = 1'b1;
          r.res.err  = ERR_DEPTH;
          r.depth    = DEPTH_W'(1);
        end else begin
          r.depth     = d + DEPTH_W'(1);
          r.res.data  = c;
          r.res.valid = 1'b1;
        end
      end
      CH_RPAREN: begin
        if (d <= DEPTH_W'(1)) begin
          r.res.done = 1'b1;
          r.depth    = DEPTH_W'(1);
        end else begin
          r.depth     = d - DEPTH_W'(1);
          r.res.data  = c;
          r.res.valid = 1'b1;
        end
      end
      CH_CR: begin
        r.res.data  = CH_LF;
        r.res.valid = 1'b1;
        r.mode      = MODE_CR;
      end
      CH_BSLASH: begin
        r.emit = 1'b0;
        r.mode = MODE_ESCAPE;
      end
      default: begin
        r.res.data  = c;
        r.res.valid = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign nb        = normal_fn(byte_in, depth_r);
  assign oct_shift = {oct_r[4:0], byte_in[2:0]};

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    oct_nxt   = oct_r;
    push      = '0;
    if (eod_in) begin
      if (mode_r == MODE_OCT1 || mode_r == MODE_OCT2) begin
        push.r0.data  = oct_r;
        push.r0.valid = 1'b1;
        push.r1.done  = 1'b1;
        push.r1.err   = ERR_EOD;
        push.n        = 2'd2;
      end else begin
        push.r0.done = 1'b1;
        push.r0.err  = ERR_EOD;
        push.n       = 2'd1;
      end
      mode_nxt  = MODE_NORMAL;
      depth_nxt = DEPTH_W'(1);
      oct_nxt   = '0;
    end else begin
      case (mode_r)
        MODE_ESCAPE: begin
          mode_nxt      = MODE_NORMAL;
          push.r0.valid = 1'b1;
          push.n        = 2'd1;
          case (byte_in)
            CH_LC_N: push.r0.data = CH_LF;
            CH_LC_R: push.r0.data = CH_CR;
            CH_LC_T: push.r0.data = CH_TAB;
            CH_LC_B: push.r0.data = CH_BS;
            CH_LC_F: push.r0.data = CH_FF;
            CH_CR: begin
              push     = '0;
              mode_nxt = MODE_ESC_CR;
            end
            CH_LF: push = '0;
            default: begin
              if (byte_in inside {[CH_ZERO:CH_SEVEN]}) begin
                push     = '0;
                oct_nxt  = {5'b0, byte_in[2:0]};
                mode_nxt = MODE_OCT1;
              end else begin
                push.r0.data = byte_in;
              end
            end
          endcase
        end
        MODE_OCT1, MODE_OCT2: begin
          if (byte_in inside {[CH_ZERO:CH_SEVEN]}) begin
            if (mode_r == MODE_OCT1) begin
              oct_nxt  = oct_shift;
              mode_nxt = MODE_OCT2;
            end else begin
              push.r0.data  = oct_shift;
              push.r0.valid = 1'b1;
              push.n        = 2'd1;
              oct_nxt       = '0;
              mode_nxt      = MODE_NORMAL;
            end
          end else begin
            // flush the pending octal byte, then treat the byte as text
            push.r0.data  = oct_r;
            push.r0.valid = 1'b1;
            push.r1       = nb.res;
            push.n        = nb.emit ? 2'd2 : 2'd1;
            oct_nxt       = '0;
            mode_nxt      = nb.mode;
            depth_nxt     = nb.depth;
          end
        end
        MODE_CR, MODE_ESC_CR: begin
          if (byte_in == CH_LF) begin
            mode_nxt = MODE_NORMAL;
          end else begin
            push.r0   = nb.res;
            push.n    = {1'b0, nb.emit};
            mode_nxt  = nb.mode;
            depth_nxt = nb.depth;
          end
        end
        default: begin
          push.r0   = nb.res;
          push.n    = {1'b0, nb.emit};
          mode_nxt  = nb.mode;
          depth_nxt = nb.depth;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      depth_r <= DEPTH_W'(1);
      oct_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      oct_r   <= oct_nxt;
    end
  end

  `LSU_ASSERT(a_depth_range, depth_r >= DEPTH_W'(1) && depth_r <= DEPTH_W'(MAX_NEST_DEPTH),
              "nesting depth out of range")
  `LSU_ASSERT_IMP(a_done_last, fire && push.n == 2'd2, !push.r0.done,
                  "string end result not last")
  `LSU_ASSERT_IMP(a_oct_idle, mode_r != MODE_OCT1 && mode_r != MODE_OCT2, oct_r == 8'd0,
                  "octal value left over outside an octal escape")
endmodule

>>> hw/rtl/lsu_out_fifo.sv
// Four-entry result queue taking up to two results per cycle while it holds at most two entries.
`include "literal_string_unescape_top_assert.svh"
module lsu_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  lsu_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_string_done,
  output logic [1:0]     out_error_code
);
  import lsu_pkg::*;

  result_t    entry_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_eff;
  logic       pop;
  result_t    head;

  assign n_eff     = push_en ? push.n : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign room      = cnt_r <= 3'd2;
  assign out_valid = cnt_r != 3'd0;
  assign head      = entry_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + {1'b0, n_eff} - {2'b0, pop};

  assign out_byte        = head.data;
  assign out_byte_valid  = head.valid;
  assign out_string_done = head.done;
  assign out_error_code  = head.err;

  always_ff @(posedge clk) begin
    if (n_eff != 2'd0) entry_r[wr_ptr_r] <= push.r0;
    if (n_eff == 2'd2) entry_r[wr_ptr_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_eff;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_nxt;
    end
  end

  `LSU_ASSERT(a_cnt_max, cnt_r <= 3'd4, "queue count overflow")
  `LSU_ASSERT_IMP(a_push_room, n_eff != 2'd0, room, "push without room")
  `LSU_ASSERT_NXT(a_pop_count, pop && n_eff == 2'd0, cnt_r == $past(cnt_r) - 3'd1,
                  "pop did not drain count")
endmodule
